// File: hw/rtl/dqme_pkg.sv
// ----------------------------------------------------------------------------
// dqme_pkg
// Shared types and constants for the DNS query message encoder: the input
// operation codes, the sequencer states, the fixed header bytes and the
// record that carries one output byte from the sequencer to the top level.
// ----------------------------------------------------------------------------
package dqme_pkg;

    // Input operation codes. The fourth code is unused and ignored.
    localparam logic [1:0] OP_START  = 2'd0;
    localparam logic [1:0] OP_CHAR   = 2'd1;
    localparam logic [1:0] OP_FINISH = 2'd2;

    // Characters that end a label.
    localparam logic [7:0] CH_DOT = 8'h2E;
    localparam logic [7:0] CH_NUL = 8'h00;

    // Configuration register indexes.
    localparam logic CFG_LEN_EN = 1'b0;
    localparam logic CFG_QTYPE  = 1'b1;

    // Reset value of the query type low byte (type A).
    localparam logic [7:0] QTYPE_RESET = 8'h01;

    // Fixed part of the message length: header, first length byte, root byte, type and class.
    localparam logic [8:0] MSG_FIXED_LEN = 9'd18;

    // Positions within the start sequence: two length bytes, then the header.
    localparam logic [3:0] HIDX_LEN_HI = 4'd0;
    localparam logic [3:0] HIDX_LEN_LO = 4'd1;
    localparam logic [3:0] HIDX_HDR0   = 4'd2;
    localparam logic [3:0] HIDX_LAST   = 4'd13;

    // Positions within the suffix: root, type high, type low, class high, low.
    localparam logic [3:0] SIDX_QTYPE = 4'd2;
    localparam logic [3:0] SIDX_LAST  = 4'd4;
    localparam logic [7:0] CLASS_IN_LO = 8'h01;

    // Header: ID 0, flags with recursion desired, one question.
    localparam logic [7:0] HDR_BYTES [12] = '{
        8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'h01,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
    };

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HDR,
        ST_LEN,
        ST_LABEL,
        ST_SUF
    } t_state;

    // One output byte offered by the sequencer.
    typedef struct packed {
        logic       valid;
        logic [7:0] data;
        logic       last;
        logic       msg_end;
        logic       too_long;
    } t_emit;

endpackage

// File: hw/rtl/dqme_label_ram.sv
// ----------------------------------------------------------------------------
// dqme_label_ram
// Label buffer: one write port and one read port, with the read data
// registered and held while no read is issued.
// ----------------------------------------------------------------------------
module dqme_label_ram #(
    parameter int MAX_LABEL = 63,
    parameter int AW        = 6
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [7:0]    o_rdata
);

    logic [7:0] r_mem [MAX_LABEL];
    logic [7:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/dqme_seq.sv
// ----------------------------------------------------------------------------
// dqme_seq
// Message sequencer: takes items, keeps the label count and overflow flag,
// writes name characters to the label buffer and steps through the start
// sequence, label flushes and the suffix one byte per cycle, unless stalled.
// ----------------------------------------------------------------------------
module dqme_seq #(
    parameter int MAX_LABEL = 63,
    parameter int AW        = 6,
    parameter int CW        = 6
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_take,
    input  logic [1:0]       i_op,
    input  logic [7:0]       i_name_byte,
    input  logic [7:0]       i_name_length,
    input  logic             i_len_en,
    input  logic [7:0]       i_qtype,
    input  logic             i_load_ok,
    output logic             o_idle,
    output dqme_pkg::t_emit  o_emit,
    output logic             o_mem_we,
    output logic [AW-1:0]    o_mem_waddr,
    output logic [7:0]       o_mem_wdata,
    output logic             o_mem_re,
    output logic [AW-1:0]    o_mem_raddr,
    input  logic [7:0]       i_mem_rdata
);
    import dqme_pkg::*;

    t_state        r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_ovf, n_ovf;
    logic [CW-1:0] r_fcnt, n_fcnt;
    logic          r_tl, n_tl;
    logic [CW-1:0] r_idx, n_idx;
    logic [3:0]    r_hidx, n_hidx;
    logic [7:0]    r_len, n_len;

    logic          sep;
    logic          label_last;
    logic [8:0]    msg_len;
    logic [CW-1:0] idx_inc;

    assign sep        = (i_name_byte == CH_DOT) || (i_name_byte == CH_NUL);
    assign label_last = (r_idx == (r_fcnt - 1'b1));
    assign msg_len    = {1'b0, r_len} + MSG_FIXED_LEN;
    assign idx_inc    = r_idx + 1'b1;
    assign o_idle     = (r_state == ST_IDLE);

    // Next state and next register values.
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_ovf   = r_ovf;
        n_fcnt  = r_fcnt;
        n_tl    = r_tl;
        n_idx   = r_idx;
        n_hidx  = r_hidx;
        n_len   = r_len;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_take) begin
                    case (i_op)
                        OP_START: begin
                            n_cnt   = '0;
                            n_ovf   = 1'b0;
                            n_len   = i_name_length;
                            n_hidx  = i_len_en ? HIDX_LEN_HI : HIDX_HDR0;
                            n_state = ST_HDR;
                        end
                        OP_CHAR: begin
                            if (sep) begin
                                n_fcnt  = r_cnt;
                                n_tl    = r_ovf;
                                n_cnt   = '0;
                                n_ovf   = 1'b0;
                                n_idx   = '0;
                                n_state = ST_LEN;
                            end else if (r_cnt < CW'(MAX_LABEL)) begin
                                n_cnt = r_cnt + 1'b1;
                            end else begin
                                n_ovf = 1'b1;
                            end
                        end
                        OP_FINISH: begin
                            n_cnt   = '0;
                            n_ovf   = 1'b0;
                            n_hidx  = '0;
                            n_state = ST_SUF;
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_HDR: begin
                if (i_load_ok) begin
                    n_hidx = r_hidx + 1'b1;
                    if (r_hidx == HIDX_LAST) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_LEN: begin
                if (i_load_ok) begin
                    n_state = (r_fcnt == '0) ? ST_IDLE : ST_LABEL;
                end
            end
            ST_LABEL: begin
                if (i_load_ok) begin
                    n_idx = idx_inc;
                    if (label_last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_SUF: begin
                if (i_load_ok) begin
                    n_hidx = r_hidx + 1'b1;
                    if (r_hidx == SIDX_LAST) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Output byte and label buffer accesses.
    always_comb begin
        o_emit      = '0;
        o_mem_we    = 1'b0;
        o_mem_waddr = r_cnt[AW-1:0];
        o_mem_wdata = i_name_byte;
        o_mem_re    = 1'b0;
        o_mem_raddr = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_take && (i_op == OP_CHAR)) begin
                    o_mem_we = !sep && (r_cnt < CW'(MAX_LABEL));
                    o_mem_re = sep;
                end
            end
            ST_HDR: begin
                o_emit.valid = i_load_ok;
                o_emit.last  = (r_hidx == HIDX_LAST);
                if (r_hidx == HIDX_LEN_HI) begin
                    o_emit.data = {7'd0, msg_len[8]};
                end else if (r_hidx == HIDX_LEN_LO) begin
                    o_emit.data = msg_len[7:0];
                end else begin
                    o_emit.data = HDR_BYTES[r_hidx - HIDX_HDR0];
                end
            end
            ST_LEN: begin
                o_emit.valid    = i_load_ok;
                o_emit.data     = 8'(r_fcnt);
                o_emit.last     = (r_fcnt == '0);
                o_emit.too_long = r_tl;
            end
            ST_LABEL: begin
                o_emit.valid    = i_load_ok;
                o_emit.data     = i_mem_rdata;
                o_emit.last     = label_last;
                o_emit.too_long = r_tl;
                // Fetch the next byte while this one goes out.
                o_mem_re        = i_load_ok && !label_last;
                o_mem_raddr     = idx_inc[AW-1:0];
            end
            ST_SUF: begin
                o_emit.valid   = i_load_ok;
                o_emit.last    = (r_hidx == SIDX_LAST);
                o_emit.msg_end = (r_hidx == SIDX_LAST);
                if (r_hidx == SIDX_QTYPE) begin
                    o_emit.data = i_qtype;
                end else if (r_hidx == SIDX_LAST) begin
                    o_emit.data = CLASS_IN_LO;
                end else begin
                    o_emit.data = 8'h00;
                end
            end
            default: begin
                o_emit = '0;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_ovf   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_ovf   <= n_ovf;
        end
    end

    // Working registers of the current run.
    always_ff @(posedge i_clk) begin
        r_fcnt <= n_fcnt;
        r_tl   <= n_tl;
        r_idx  <= n_idx;
        r_hidx <= n_hidx;
        r_len  <= n_len;
    end

endmodule

// File: hw/rtl/dns_query_message_encoder.sv
// ----------------------------------------------------------------------------
// dns_query_message_encoder
// Builds a DNS query message one byte per output item from start, name
// character and finish items.
// ----------------------------------------------------------------------------
// A start item emits the optional two-byte message length and the 12-byte
// header, name characters are buffered per label in a small RAM, and a dot or
// zero flushes the label as a length byte and its characters; a finish item
// emits the root byte, the query type and class IN. Items are taken one at a
// time by a single sequencer, which takes no new item until the bytes of the
// last one have been loaded into the output register, and offers each byte
// only when the output register can take it. Label bytes come out of the
// RAM's registered read port, fetched one byte ahead of the output register.
// ----------------------------------------------------------------------------
module dns_query_message_encoder #(
    parameter int MAX_LABEL = 63
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // Configuration writes.
    input  logic       i_cfg_we,
    input  logic       i_cfg_index,
    input  logic [7:0] i_cfg_data,
    // Input items.
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [1:0] i_op,
    input  logic [7:0] i_name_byte,
    input  logic [7:0] i_name_length,
    // Output items.
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_out_byte,
    output logic       o_last,
    output logic       o_message_end,
    output logic       o_label_too_long
);
    import dqme_pkg::*;

    localparam int AW = (MAX_LABEL > 1) ? $clog2(MAX_LABEL) : 1;
    localparam int CW = $clog2(MAX_LABEL + 1);

    logic       r_len_en;
    logic [7:0] r_qtype;
    logic       r_out_valid;
    logic [7:0] r_out_byte;
    logic       r_last;
    logic       r_msg_end;
    logic       r_too_long;

    logic          seq_idle;
    logic          in_take;
    logic          load_ok;
    t_emit         emit;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [7:0]    mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;
    logic [7:0]    mem_rdata;

    // Input side is open whenever the sequencer has no run in progress.
    assign o_in_stall = !seq_idle;
    assign in_take    = i_in_valid && seq_idle;

    // The output register takes a new byte when empty or being emptied.
    assign load_ok = !r_out_valid || !i_out_stall;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len_en <= 1'b0;
            r_qtype  <= QTYPE_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_LEN_EN: r_len_en <= i_cfg_data[0];
                CFG_QTYPE:  r_qtype  <= i_cfg_data;
                default:    r_len_en <= r_len_en;
            endcase
        end
    end

    dqme_seq #(
        .MAX_LABEL (MAX_LABEL),
        .AW        (AW),
        .CW        (CW)
    ) u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_take     (in_take),
        .i_op          (i_op),
        .i_name_byte   (i_name_byte),
        .i_name_length (i_name_length),
        .i_len_en      (r_len_en),
        .i_qtype       (r_qtype),
        .i_load_ok     (load_ok),
        .o_idle        (seq_idle),
        .o_emit        (emit),
        .o_mem_we      (mem_we),
        .o_mem_waddr   (mem_waddr),
        .o_mem_wdata   (mem_wdata),
        .o_mem_re      (mem_re),
        .o_mem_raddr   (mem_raddr),
        .i_mem_rdata   (mem_rdata)
    );

    dqme_label_ram #(
        .MAX_LABEL (MAX_LABEL),
        .AW        (AW)
    ) u_label_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // Output register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_ok) begin
            r_out_valid <= emit.valid;
        end
    end

    // Output register payload.
    always_ff @(posedge i_clk) begin
        if (load_ok && emit.valid) begin
            r_out_byte <= emit.data;
            r_last     <= emit.last;
            r_msg_end  <= emit.msg_end;
            r_too_long <= emit.too_long;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_out_byte       = r_out_byte;
    assign o_last           = r_last;
    assign o_message_end    = r_msg_end;
    assign o_label_too_long = r_too_long;

    // The sequencer offers a byte only when the output register can take it.
    a_emit_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit.valid |-> load_ok)
        else $error("byte offered while the output register is full");

    // The end of the message is always the end of a run.
    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_msg_end) |-> r_last)
        else $error("message end without run end");

    // No new item is taken while a run is still producing bytes.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit.valid |-> o_in_stall)
        else $error("input open during an output run");

endmodule

// File: tb/tb_dns_query_message_encoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dns_query_message_encoder
// Self-checking bench for the DNS query encoder. Queries and loose items are
// queued by the stimulus process, driven by a clocked driver and mirrored by
// a predictor of the message bytes; each output item is compared with the
// oldest predicted byte under changing idling, stalling and register values.
// ----------------------------------------------------------------------------
module tb_dns_query_message_encoder;
    import dqme_pkg::*;

    localparam int         LABEL_MAX      = 63;
    localparam logic [1:0] OP_UNUSED      = 2'd3;
    localparam int         RANDOM_ITEMS   = 24;
    localparam int         SETTLE_CYCLES  = 16;
    localparam int         DRAIN_CYCLES   = 100;
    localparam int         HOLD_CYCLES    = 300;
    localparam int         WATCHDOG_LIMIT = 5000;

    // One input item of the encoder.
    typedef struct {
        logic [1:0] op;
        logic [7:0] name_byte;
        logic [7:0] name_length;
    } query_item_t;

    // One predicted byte of the message with its markers.
    typedef struct {
        logic [7:0] data;
        logic       last;
        logic       msg_end;
        logic       too_long;
    } msg_byte_t;

    logic       i_clk         = 1'b0;
    logic       i_rst_n       = 1'b0;
    logic       i_cfg_we      = 1'b0;
    logic       i_cfg_index   = 1'b0;
    logic [7:0] i_cfg_data    = 8'h00;
    logic       i_in_valid    = 1'b0;
    logic [1:0] i_op          = OP_START;
    logic [7:0] i_name_byte   = 8'h00;
    logic [7:0] i_name_length = 8'h00;
    logic       i_out_stall   = 1'b0;
    logic       o_in_stall;
    logic       o_out_valid;
    logic [7:0] o_out_byte;
    logic       o_last;
    logic       o_message_end;
    logic       o_label_too_long;

    // Queued input items and predicted message bytes.
    query_item_t pending_items [$];
    msg_byte_t   expected_bytes [$];

    // Predictor copy of the label state and the registers.
    logic [7:0] label_bytes [LABEL_MAX];
    int         label_len    = 0;
    logic       label_over   = 1'b0;
    logic       len_field_on = 1'b0;
    logic [7:0] qtype_lo     = QTYPE_RESET;

    // Idling controls, set by the stimulus process.
    int send_idle_pct = 0;
    int stall_pct     = 0;
    int hold_token    = 0;
    int hold_seen     = 0;
    int hold_left     = 0;

    logic in_taken    = 1'b0;
    int   quiet_cycles = 0;
    int   fail_count  = 0;
    int   items_sent  = 0;

    dns_query_message_encoder #(
        .MAX_LABEL(LABEL_MAX)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_op            (i_op),
        .i_name_byte     (i_name_byte),
        .i_name_length   (i_name_length),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_out_byte      (o_out_byte),
        .o_last          (o_last),
        .o_message_end   (o_message_end),
        .o_label_too_long(o_label_too_long)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic void add_byte(input logic [7:0] data, input logic last,
                                     input logic msg_end, input logic too_long);
        msg_byte_t b;
        b.data     = data;
        b.last     = last;
        b.msg_end  = msg_end;
        b.too_long = too_long;
        expected_bytes.push_back(b);
    endfunction

    // Work out the message bytes that one accepted item produces.
    function automatic void predict_message(input logic [1:0] op, input logic [7:0] ch,
                                            input logic [7:0] nlen);
        logic [15:0] msg_len;
        int          cnt;
        case (op)
            OP_START: begin
                label_len  = 0;
                label_over = 1'b0;
                if (len_field_on) begin
                    msg_len = 16'(nlen) + 16'(MSG_FIXED_LEN);
                    add_byte(msg_len[15:8], 1'b0, 1'b0, 1'b0);
                    add_byte(msg_len[7:0], 1'b0, 1'b0, 1'b0);
                end
                for (int i = 0; i < 12; i++)
                    add_byte(HDR_BYTES[i], i == 11, 1'b0, 1'b0);
            end
            OP_CHAR: begin
                if (ch == CH_DOT || ch == CH_NUL) begin
                    // A separator flushes the label, even an empty one.
                    cnt = label_len;
                    add_byte(8'(cnt), cnt == 0, 1'b0, label_over);
                    for (int i = 0; i < cnt; i++)
                        add_byte(label_bytes[i], i == cnt - 1, 1'b0, label_over);
                    label_len  = 0;
                    label_over = 1'b0;
                end else if (label_len < LABEL_MAX) begin
                    label_bytes[label_len] = ch;
                    label_len++;
                end else begin
                    label_over = 1'b1;
                end
            end
            OP_FINISH: begin
                // A pending label is dropped, not flushed.
                label_len  = 0;
                label_over = 1'b0;
                add_byte(8'h00, 1'b0, 1'b0, 1'b0);
                add_byte(8'h00, 1'b0, 1'b0, 1'b0);
                add_byte(qtype_lo, 1'b0, 1'b0, 1'b0);
                add_byte(8'h00, 1'b0, 1'b0, 1'b0);
                add_byte(CLASS_IN_LO, 1'b1, 1'b1, 1'b0);
            end
            default: begin
            end
        endcase
    endfunction

    // Driver: offers the next queued item once the current one is taken.
    always @(negedge i_clk) begin : driver
        query_item_t item;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_taken) begin
            if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                item = pending_items.pop_front();
                i_op          <= item.op;
                i_name_byte   <= item.name_byte;
                i_name_length <= item.name_length;
                i_in_valid    <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off on request.
    always @(negedge i_clk) begin
        if (hold_seen != hold_token) begin
            hold_seen   <= hold_token;
            hold_left   <= HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Monitor: register writes, output checks, prediction and the watchdog.
    always @(posedge i_clk) begin : monitor
        msg_byte_t want;
        if (i_rst_n) begin
            in_taken <= i_in_valid && !o_in_stall;
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_LEN_EN)
                    len_field_on = i_cfg_data[0];
                else
                    qtype_lo = i_cfg_data;
            end
            if (o_out_valid && !i_out_stall) begin
                if (expected_bytes.size() == 0) begin
                    $error("unexpected output item: out_byte %02h", o_out_byte);
                    fail_count++;
                end else begin
                    want = expected_bytes.pop_front();
                    if (o_out_byte !== want.data) begin
                        $error("out_byte: expected %02h, got %02h", want.data, o_out_byte);
                        fail_count++;
                    end
                    if (o_last !== want.last) begin
                        $error("last: expected %0b, got %0b", want.last, o_last);
                        fail_count++;
                    end
                    if (o_message_end !== want.msg_end) begin
                        $error("message_end: expected %0b, got %0b", want.msg_end,
                               o_message_end);
                        fail_count++;
                    end
                    if (o_label_too_long !== want.too_long) begin
                        $error("label_too_long: expected %0b, got %0b", want.too_long,
                               o_label_too_long);
                        fail_count++;
                    end
                end
            end
            if (i_in_valid && !o_in_stall)
                predict_message(i_op, i_name_byte, i_name_length);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
                $display("dns_query_message_encoder: mismatch");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    task automatic queue_item(input logic [1:0] op, input logic [7:0] name_byte,
                              input logic [7:0] name_length);
        query_item_t item;
        item.op          = op;
        item.name_byte   = name_byte;
        item.name_length = name_length;
        pending_items.push_back(item);
        if (op != OP_UNUSED)
            items_sent++;
    endtask

    // A label character that is neither a dot nor the terminator.
    function automatic logic [7:0] name_char();
        logic [7:0] ch;
        do ch = 8'($urandom_range(1, 255));
        while (ch == CH_DOT);
        return ch;
    endfunction

    // A whole query with random labels; long_len forces the first label size.
    task automatic queue_query(input int long_len);
        int n_labels;
        int lab_len [4];
        int name_len;
        int ending;
        n_labels = $urandom_range(1, 4);
        name_len = 0;
        for (int i = 0; i < n_labels; i++) begin
            if (i == 0 && long_len > 0)
                lab_len[i] = long_len;
            else
                lab_len[i] = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 8);
            name_len += lab_len[i] + ((i > 0) ? 1 : 0);
        end
        // Now and then the announced length does not match the name.
        queue_item(OP_START, 8'($urandom),
                   ($urandom_range(9) == 0) ? 8'($urandom) : 8'(name_len));
        for (int i = 0; i < n_labels; i++) begin
            if (i > 0)
                queue_item(OP_CHAR, CH_DOT, 8'($urandom));
            for (int j = 0; j < lab_len[i]; j++) begin
                queue_item(OP_CHAR, name_char(), 8'($urandom));
                if ($urandom_range(29) == 0)
                    queue_item(OP_UNUSED, 8'($urandom), 8'($urandom));
            end
        end
        ending = $urandom_range(19);
        case (ending)
            0: begin
                // Finish right after a label, which discards it.
            end
            1: queue_item(OP_START, 8'($urandom), 8'($urandom));
            2: begin
                queue_item(OP_CHAR, CH_DOT, 8'($urandom));
                queue_item(OP_CHAR, CH_NUL, 8'($urandom));
            end
            default: queue_item(OP_CHAR, CH_NUL, 8'($urandom));
        endcase
        queue_item(OP_FINISH, 8'($urandom), 8'($urandom));
    endtask

    task automatic queue_noise(input int count);
        for (int k = 0; k < count; k++)
            queue_item(2'($urandom), 8'($urandom), 8'($urandom));
    endtask

    // Wait until every queued item is taken and every predicted byte is out.
    task automatic wait_results_done();
        while (pending_items.size() != 0 || i_in_valid || expected_bytes.size() != 0)
            @(posedge i_clk);
    endtask

    // Idle point for register writes: a trailing character may still be busy.
    task automatic settle_idle();
        wait_results_done();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic index, input logic [7:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin : stimulus
        int phase_start;
        bit paused;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed items with the reset register values.
        queue_item(OP_START, 8'hFF, 8'h00);
        queue_item(OP_CHAR, 8'h61, 8'hFF);
        queue_item(OP_CHAR, 8'hFF, 8'h00);
        queue_item(OP_CHAR, CH_DOT, 8'h00);
        queue_item(OP_CHAR, CH_DOT, 8'hFF);
        queue_item(OP_CHAR, 8'h01, 8'h00);
        queue_item(OP_CHAR, CH_NUL, 8'h00);
        queue_item(OP_FINISH, 8'h00, 8'hFF);
        queue_item(OP_UNUSED, 8'hFF, 8'hFF);
        // Finish and start in the middle of a label drop the label.
        queue_item(OP_CHAR, 8'h78, 8'h00);
        queue_item(OP_FINISH, 8'hFF, 8'h00);
        queue_item(OP_CHAR, CH_NUL, 8'h00);
        queue_item(OP_CHAR, 8'h79, 8'h00);
        queue_item(OP_START, 8'h00, 8'hFF);
        queue_item(OP_CHAR, CH_DOT, 8'h00);
        queue_item(OP_FINISH, 8'h00, 8'h00);
        settle_idle();

        // Length prefix on, largest and smallest names, top query type.
        write_reg(CFG_LEN_EN, 8'h01);
        write_reg(CFG_QTYPE, 8'hFF);
        queue_item(OP_START, 8'h00, 8'hFF);
        queue_item(OP_START, 8'hFF, 8'h00);
        queue_item(OP_CHAR, 8'h7A, 8'h00);
        queue_item(OP_CHAR, CH_NUL, 8'hFF);
        queue_item(OP_FINISH, 8'h00, 8'h00);
        queue_item(OP_UNUSED, 8'h00, 8'h00);

        // Random phases, each with its own registers and idling.
        for (int phase = 0; phase < 4; phase++) begin
            settle_idle();
            case (phase)
                0: begin
                    write_reg(CFG_LEN_EN, 8'h01);
                    write_reg(CFG_QTYPE, 8'd28);
                    send_idle_pct = 0;
                    stall_pct     = 0;
                    hold_token++;
                end
                1: begin
                    write_reg(CFG_LEN_EN, 8'h00);
                    write_reg(CFG_QTYPE, 8'h00);
                    send_idle_pct = 71;
                    stall_pct     = 0;
                end
                2: begin
                    write_reg(CFG_LEN_EN, 8'($urandom_range(1)));
                    write_reg(CFG_QTYPE, 8'hFF);
                    send_idle_pct = 0;
                    stall_pct     = 71;
                end
                default: begin
                    write_reg(CFG_LEN_EN, 8'($urandom_range(1)));
                    write_reg(CFG_QTYPE, 8'($urandom));
                    send_idle_pct = 10;
                    stall_pct     = 10;
                end
            endcase
            phase_start = items_sent;
            paused = 1'b0;
            while (items_sent - phase_start < RANDOM_ITEMS / 4) begin
                if ($urandom_range(99) < 85)
                    queue_query(0);
                else
                    queue_noise($urandom_range(1, 4));
                // The sender stops once until the block has drained.
                if (phase == 2 && !paused && items_sent - phase_start >= RANDOM_ITEMS / 8)
                begin
                    wait_results_done();
                    paused = 1'b1;
                end
            end
            // An over-long label, which also fills the buffer to the limit.
            if (phase == 1)
                queue_query(LABEL_MAX + 3);
        end

        wait_results_done();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && expected_bytes.size() == 0)
            $display("dns_query_message_encoder: match");
        else
            $display("dns_query_message_encoder: mismatch");
        $finish;
    end

endmodule
